// ===== hdl/sls_pkg.sv =====
package sls_pkg;

  // field widths of the channel words
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned INDEX_W  = 4;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned STATUS_W = 2;

  // number of cells in the chain
  localparam int unsigned CAPACITY = 16;

  // internal count holds 0 .. CAPACITY, a cell position 0 .. CAPACITY-1
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned POS_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  // common width for index against position and count
  localparam int unsigned CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_READ   = 2'd2
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_e;

  // broadcast to every cell: the operand and the current fill
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [INDEX_W-1:0]        index;
    logic [CNT_W-1:0]          count;
  } sls_cmp_t;

  // shift commands, already qualified by handshake and full / found
  typedef struct packed {
    logic ins_go;
    logic del_go;
  } sls_cmd_t;

  // per-cell compare results
  typedef struct packed {
    logic lt;   // occupied and smaller than the operand
    logic hit;  // first occupied cell equal to the operand
  } sls_flags_t;

endpackage

// ===== hdl/sls_in_if.sv =====
interface sls_in_if import sls_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [ACTION_W-1:0]       action;
  logic signed [VALUE_W-1:0] value;
  logic [INDEX_W-1:0]        index;

  modport source (output valid, output action, output value, output index, input ready);
  modport sink   (input valid, input action, input value, input index, output ready);
endinterface

// ===== hdl/sls_out_if.sv =====
interface sls_out_if import sls_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] read_value;
  logic [COUNT_W-1:0]        count;
  logic [STATUS_W-1:0]       status;

  modport source (output valid, output read_value, output count, output status, input ready);
  modport sink   (input valid, input read_value, input count, input status, output ready);
endinterface

// ===== hdl/sls_cell.sv =====
module sls_cell import sls_pkg::*; (
  input  logic                      clk_i,
  input  logic [POS_W-1:0]          pos_i,
  input  sls_cmp_t                  cmp_i,
  input  sls_cmd_t                  cmd_i,
  input  logic signed [VALUE_W-1:0] prev_value_i,
  input  logic                      prev_lt_i,
  input  logic signed [VALUE_W-1:0] next_value_i,
  output logic signed [VALUE_W-1:0] value_o,
  output sls_flags_t                flags_o,
  output logic signed [VALUE_W-1:0] rd_o
);

  logic signed [VALUE_W-1:0] value_q, value_d;
  logic occ, lt, eq;

  assign occ = CNT_W'(pos_i) < cmp_i.count;
  assign lt  = occ && ($signed(value_q) < $signed(cmp_i.value));
  assign eq  = occ && (value_q == cmp_i.value);

  assign flags_o.lt  = lt;
  assign flags_o.hit = eq && prev_lt_i;

  // read tap, or-ed together over the chain
  assign rd_o = (CMP_W'(cmp_i.index) == CMP_W'(pos_i)) ? value_q : '0;

  always_comb begin
    value_d = value_q;
    if (cmd_i.ins_go) begin
      // smaller values stay, the first cell past them takes the new one, later cells take their neighbour's value
      if (!lt) begin
        value_d = prev_lt_i ? cmp_i.value : prev_value_i;
      end
    end else if (cmd_i.del_go && !lt) begin
      value_d = next_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

// ===== hdl/sorted_list_store_core.sv =====
// result: the result of an accepted word is held in the output register
// throughput: one word per cycle while the output side takes results; every cell
//   compares and shifts in the same cycle, so the whole chain settles in one step
// reset: rst_ni clears the count and the output valid; cell contents stay as they are
//   and are only read below the count, so no clearing pass is needed
module sorted_list_store_core import sls_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  sls_in_if.sink    in_i,
  sls_out_if.source out_o
);

  // fill state
  logic [CNT_W-1:0] count_q, count_d;

  // output register
  logic                      out_valid_q;
  logic signed [VALUE_W-1:0] rd_value_q;
  logic [COUNT_W-1:0]        count_field_q;
  status_e                   status_q;

  // chain wiring
  logic signed [VALUE_W-1:0] cell_value [CAPACITY];
  logic signed [VALUE_W-1:0] cell_rd    [CAPACITY];
  sls_flags_t                cell_flags [CAPACITY];
  logic [CAPACITY-1:0]       hit_vec;

  sls_cmp_t cmp;
  sls_cmd_t cmd;

  logic fire, full, found, bad_index;
  logic is_ins, is_del, is_read;
  logic signed [VALUE_W-1:0] rd_any;
  status_e status_d;

  // a new word goes in whenever the result slot is empty or being drained
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign fire       = in_i.valid && in_i.ready;

  assign full = (count_q == CNT_W'(CAPACITY));

  // action decode, the unused code does nothing
  always_comb begin
    is_ins  = 1'b0;
    is_del  = 1'b0;
    is_read = 1'b0;
    unique case (in_i.action)
      ACT_INSERT: is_ins  = 1'b1;
      ACT_DELETE: is_del  = 1'b1;
      ACT_READ:   is_read = 1'b1;
      default:    ;
    endcase
  end

  assign cmp.value = in_i.value;
  assign cmp.index = in_i.index;
  assign cmp.count = count_q;

  // first equal cell anywhere in the chain, and the or of the read taps; lt is a prefix so at most one hit
  always_comb begin
    found  = 1'b0;
    rd_any = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      found  = found | cell_flags[k].hit;
      rd_any = rd_any | cell_rd[k];
    end
  end

  assign cmd.ins_go = fire && is_ins && !full;
  assign cmd.del_go = fire && is_del && found;

  assign bad_index = CMP_W'(in_i.index) >= CMP_W'(count_q);

  // the chain of compare-and-shift cells, cell 0 holds the smallest value
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic signed [VALUE_W-1:0] prev_value, next_value;
    logic                      prev_lt;

    if (k == 0) begin : g_head
      assign prev_value = '0;
      assign prev_lt    = 1'b1;
    end else begin : g_body
      assign prev_value = cell_value[k-1];
      assign prev_lt    = cell_flags[k-1].lt;
    end

    if (k == CAPACITY - 1) begin : g_tail
      assign next_value = cell_value[k];
    end else begin : g_inner
      assign next_value = cell_value[k+1];
    end

    assign hit_vec[k] = cell_flags[k].hit;

    sls_cell u_cell (
      .clk_i        (clk_i),
      .pos_i        (POS_W'(k)),
      .cmp_i        (cmp),
      .cmd_i        (cmd),
      .prev_value_i (prev_value),
      .prev_lt_i    (prev_lt),
      .next_value_i (next_value),
      .value_o      (cell_value[k]),
      .flags_o      (cell_flags[k]),
      .rd_o         (cell_rd[k])
    );
  end

  // count after the operation
  always_comb begin
    count_d = count_q;
    if (cmd.ins_go) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd.del_go) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  // status of the word being accepted
  always_comb begin
    status_d = ST_OK;
    if (is_ins && full) begin
      status_d = ST_FULL;
    end else if (is_del && !found) begin
      status_d = ST_NOT_FOUND;
    end else if (is_read && bad_index) begin
      status_d = ST_BAD_INDEX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted word
  always_ff @(posedge clk_i) begin
    if (fire) begin
      rd_value_q    <= (is_read && !bad_index) ? rd_any : '0;
      count_field_q <= COUNT_W'(count_d);
      status_q      <= status_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.read_value = rd_value_q;
  assign out_o.count      = count_field_q;
  assign out_o.status     = status_q;

  // fill never runs past the chain length
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("count beyond capacity");

  // an accepted insert into a store with room grows the count by one
  a_ins_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && is_ins && !full) |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("insert did not grow the count");

  // a full status is only reported while the store is at capacity
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == ST_FULL) |-> full)
    else $error("full status with room left");

  // at most one cell claims the first match
  a_one_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit_vec))
    else $error("more than one matching cell");

  // every accepted word leaves a result waiting
  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("accepted word left no result");

endmodule
